// ----- src/mfdf_pkg.sv -----
// Shared constants, types and register codes for the median flow deadband filter.
// Used by every module and by the channel interfaces; has no dependencies of its own.

package mfdf_pkg;

    // Group size and converter resolution.
    localparam int SAMPLES    = 5;
    localparam int ADC_BITS   = 12;
    localparam int MEDIAN_POS = SAMPLES / 2;

    // Widths of the sample collection logic.
    localparam int CNT_W  = $clog2(SAMPLES);
    localparam int IDX_W  = (SAMPLES - 1 > 1) ? $clog2(SAMPLES - 1) : 1;
    localparam int RANK_W = $clog2(SAMPLES);

    // Configuration register widths.
    localparam int GAIN_W     = 16;
    localparam int OFFSET_W   = 24;
    localparam int DEADBAND_W = 18;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0]     GAIN_RESET     = 16'd4063;
    localparam logic [OFFSET_W-1:0]   OFFSET_RESET   = 24'd2873538;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 18'd45875;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN     = 2'd0,
        REG_OFFSET   = 2'd1,
        REG_DEADBAND = 2'd2
    } mfdf_reg_t;

    // Fixed point arithmetic widths.
    localparam int FRAC_W = 16;
    localparam int PROD_W = ADC_BITS + GAIN_W;
    localparam int FQ_W   = ((PROD_W > OFFSET_W) ? PROD_W : OFFSET_W) + 1;
    localparam int DIFF_W = FQ_W + 1;
    localparam int RMAG_W = FQ_W + 1 - FRAC_W;

    // Output flow range.
    localparam int FLOW_W        = 10;
    localparam int FLOW_MAX_MAG  = 2 ** (FLOW_W - 1) - 1;
    localparam int FLOW_MIN_MAG  = 2 ** (FLOW_W - 1);
    localparam logic [FLOW_W-1:0] FLOW_MAX_CODE = {1'b0, {(FLOW_W - 1){1'b1}}};
    localparam logic [FLOW_W-1:0] FLOW_MIN_CODE = {1'b1, {(FLOW_W - 1){1'b0}}};

    // Median queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One median travelling through the queue.
    typedef struct packed {
        logic                valid;
        logic [ADC_BITS-1:0] median;
    } mfdf_item_t;

    // Configuration write as seen by the back part.
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } mfdf_cfg_t;

endpackage

// ----- src/mfdf_if.sv -----
// Valid/ready channel interfaces for samples in and flow results out.
// Depends on mfdf_pkg for the payload widths.

interface mfdf_sample_if;
    logic                         valid;
    logic                         ready;
    logic [mfdf_pkg::ADC_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mfdf_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [mfdf_pkg::FLOW_W-1:0] flow;
    logic                              held;
    logic                              clipped;

    modport source (output valid, output flow, output held, output clipped, input ready);
    modport sink   (input valid, input flow, input held, input clipped, output ready);
endinterface

// ----- src/mfdf_front.sv -----
// Front part: collects samples into groups and picks the median of each full group.
// Depends on mfdf_pkg and mfdf_sample_if; pushes medians into mfdf_queue.

module mfdf_front (
    input  logic                  clk,
    input  logic                  rst_n,
    mfdf_sample_if.sink           samples,
    input  logic                  queue_full,
    output mfdf_pkg::mfdf_item_t  push
);

    logic [mfdf_pkg::CNT_W-1:0]    count_reg;
    logic [mfdf_pkg::CNT_W-1:0]    count_next;
    logic [mfdf_pkg::ADC_BITS-1:0] store_reg [mfdf_pkg::SAMPLES-1];
    logic [mfdf_pkg::ADC_BITS-1:0] grp       [mfdf_pkg::SAMPLES];
    logic [mfdf_pkg::RANK_W-1:0]   rank      [mfdf_pkg::SAMPLES];
    logic [mfdf_pkg::ADC_BITS-1:0] median;
    logic                          accept;
    logic                          last;

    // A sample is taken whenever the queue has room for a median.
    assign samples.ready = !queue_full;
    assign accept        = samples.valid && samples.ready;
    assign last          = (count_reg == mfdf_pkg::CNT_W'(mfdf_pkg::SAMPLES - 1));

    // Group counter wraps after the last sample of a group.
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = last ? '0 : count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Sample store: each slot is written at its place in the group.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mfdf_pkg::SAMPLES - 1; i++)
        begin
            if (accept && !last && count_reg[mfdf_pkg::IDX_W-1:0] == mfdf_pkg::IDX_W'(i))
            begin
                store_reg[i] <= samples.sample;
            end
        end
    end

    // Median by stable ranking: ties are ordered by position, so exactly one
    // element carries the middle rank.
    always_comb
    begin
        for (int i = 0; i < mfdf_pkg::SAMPLES - 1; i++)
        begin
            grp[i] = store_reg[i];
        end
        grp[mfdf_pkg::SAMPLES-1] = samples.sample;
        median = '0;
        for (int i = 0; i < mfdf_pkg::SAMPLES; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < mfdf_pkg::SAMPLES; j++)
            begin
                if (j != i && (grp[j] < grp[i] || (grp[j] == grp[i] && j < i)))
                begin
                    rank[i] = rank[i] + 1'b1;
                end
            end
            if (rank[i] == mfdf_pkg::RANK_W'(mfdf_pkg::MEDIAN_POS))
            begin
                median = median | grp[i];
            end
        end
    end

    // A full group sends its median on to the back part.
    assign push.valid  = accept && last;
    assign push.median = median;

endmodule

// ----- src/mfdf_queue.sv -----
// Short median queue that decouples the sample front from the arithmetic back.
// Depends on mfdf_pkg for the item type and depth.

module mfdf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mfdf_pkg::mfdf_item_t  push,
    output logic                  full,
    output mfdf_pkg::mfdf_item_t  head,
    input  logic                  pop
);

    logic [mfdf_pkg::ADC_BITS-1:0] entry_reg [mfdf_pkg::QUEUE_DEPTH];
    logic [mfdf_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [mfdf_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [mfdf_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [mfdf_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [mfdf_pkg::QCNT_W-1:0]   fill_reg;
    logic [mfdf_pkg::QCNT_W-1:0]   fill_next;
    logic                          do_push;
    logic                          do_pop;

    assign full        = (fill_reg == mfdf_pkg::QCNT_W'(mfdf_pkg::QUEUE_DEPTH));
    assign head.valid  = (fill_reg != '0);
    assign head.median = entry_reg[rd_ptr_reg];
    assign do_push     = push.valid && !full;
    assign do_pop      = pop && head.valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == mfdf_pkg::QPTR_W'(mfdf_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mfdf_pkg::QPTR_W'(mfdf_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.median;
        end
    end

endmodule

// ----- src/mfdf_back.sv -----
// Back part: scales each median to Q16 flow, rounds, saturates and applies the deadband.
// Depends on mfdf_pkg and mfdf_result_if; takes medians from mfdf_queue.

module mfdf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mfdf_pkg::mfdf_cfg_t   cfg,
    input  mfdf_pkg::mfdf_item_t  head,
    output logic                  pop,
    mfdf_result_if.source         results
);

    // Configuration registers.
    logic [mfdf_pkg::GAIN_W-1:0]     gain_reg;
    logic [mfdf_pkg::OFFSET_W-1:0]   offset_reg;
    logic [mfdf_pkg::DEADBAND_W-1:0] deadband_reg;

    // Pipeline registers.
    logic                               s1_valid_reg;
    logic [mfdf_pkg::PROD_W-1:0]        s1_prod_reg;
    logic [mfdf_pkg::PROD_W-1:0]        s1_prod_next;
    logic                               s2_valid_reg;
    logic signed [mfdf_pkg::FQ_W-1:0]   s2_fq_reg;
    logic signed [mfdf_pkg::FQ_W-1:0]   s2_fq_next;
    logic signed [mfdf_pkg::FLOW_W-1:0] s2_flow_reg;
    logic signed [mfdf_pkg::FLOW_W-1:0] s2_flow_next;
    logic                               s2_clip_reg;
    logic                               s2_clip_next;
    logic                               out_valid_reg;
    logic signed [mfdf_pkg::FLOW_W-1:0] out_flow_reg;
    logic signed [mfdf_pkg::FLOW_W-1:0] out_flow_next;
    logic                               out_held_reg;
    logic                               out_held_next;
    logic                               out_clip_reg;
    logic                               out_clip_next;
    logic signed [mfdf_pkg::FLOW_W-1:0] prev_flow_reg;

    // Combinational intermediates.
    logic                               advance;
    logic                               neg;
    logic [mfdf_pkg::FQ_W-1:0]          mag;
    logic [mfdf_pkg::FQ_W:0]            mag_round;
    logic [mfdf_pkg::RMAG_W-1:0]        r_mag;
    logic signed [mfdf_pkg::DIFF_W-1:0] diff;
    logic [mfdf_pkg::DIFF_W-1:0]        abs_diff;
    logic signed [mfdf_pkg::DIFF_W-1:0] prev_q16;

    // The whole pipeline moves together unless the output register is blocked.
    assign advance = !out_valid_reg || results.ready;
    assign pop     = advance;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= mfdf_pkg::GAIN_RESET;
            offset_reg   <= mfdf_pkg::OFFSET_RESET;
            deadband_reg <= mfdf_pkg::DEADBAND_RESET;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                mfdf_pkg::REG_GAIN:     gain_reg     <= cfg.data[mfdf_pkg::GAIN_W-1:0];
                mfdf_pkg::REG_OFFSET:   offset_reg   <= cfg.data[mfdf_pkg::OFFSET_W-1:0];
                mfdf_pkg::REG_DEADBAND: deadband_reg <= cfg.data[mfdf_pkg::DEADBAND_W-1:0];
                default:                ;
            endcase
        end
    end

    // Stage 1: median times gain.
    assign s1_prod_next = mfdf_pkg::PROD_W'(head.median) * mfdf_pkg::PROD_W'(gain_reg);

    // Stage 2: remove the offset, round half away from zero and saturate.
    always_comb
    begin
        s2_fq_next = mfdf_pkg::FQ_W'(s1_prod_reg) - mfdf_pkg::FQ_W'(offset_reg);
        neg        = s2_fq_next[mfdf_pkg::FQ_W-1];
        mag        = neg ? -s2_fq_next : s2_fq_next;
        mag_round  = {1'b0, mag} + (mfdf_pkg::FQ_W + 1)'(2 ** (mfdf_pkg::FRAC_W - 1));
        r_mag      = mag_round[mfdf_pkg::FQ_W:mfdf_pkg::FRAC_W];
        s2_clip_next = 1'b0;
        if (neg)
        begin
            if ({1'b0, r_mag} > (mfdf_pkg::RMAG_W + 1)'(mfdf_pkg::FLOW_MIN_MAG))
            begin
                s2_flow_next = mfdf_pkg::FLOW_MIN_CODE;
                s2_clip_next = 1'b1;
            end
            else
            begin
                s2_flow_next = mfdf_pkg::FLOW_W'(0) - r_mag[mfdf_pkg::FLOW_W-1:0];
            end
        end
        else
        begin
            if ({1'b0, r_mag} > (mfdf_pkg::RMAG_W + 1)'(mfdf_pkg::FLOW_MAX_MAG))
            begin
                s2_flow_next = mfdf_pkg::FLOW_MAX_CODE;
                s2_clip_next = 1'b1;
            end
            else
            begin
                s2_flow_next = r_mag[mfdf_pkg::FLOW_W-1:0];
            end
        end
    end

    // Stage 3: deadband test against the last reported flow.
    always_comb
    begin
        prev_q16 = {{(mfdf_pkg::DIFF_W - mfdf_pkg::FLOW_W - mfdf_pkg::FRAC_W)
                     {prev_flow_reg[mfdf_pkg::FLOW_W-1]}},
                    prev_flow_reg, {mfdf_pkg::FRAC_W{1'b0}}};
        diff     = mfdf_pkg::DIFF_W'(s2_fq_reg) - prev_q16;
        abs_diff = diff[mfdf_pkg::DIFF_W-1] ? -diff : diff;
        out_held_next = (abs_diff < mfdf_pkg::DIFF_W'(deadband_reg));
        out_flow_next = out_held_next ? prev_flow_reg : s2_flow_reg;
        out_clip_next = out_held_next ? 1'b0 : s2_clip_reg;
    end

    // Valid bits and the last reported flow.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_flow_reg <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= head.valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                prev_flow_reg <= out_flow_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_prod_reg <= s1_prod_next;
            s2_fq_reg   <= s2_fq_next;
            s2_flow_reg <= s2_flow_next;
            s2_clip_reg <= s2_clip_next;
            if (s2_valid_reg)
            begin
                out_flow_reg <= out_flow_next;
                out_held_reg <= out_held_next;
                out_clip_reg <= out_clip_next;
            end
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.flow    = out_flow_reg;
    assign results.held    = out_held_reg;
    assign results.clipped = out_clip_reg;

endmodule

// ----- src/median_flow_deadband_filter_top.sv -----
// Top level of the median flow deadband filter.
// Depends on mfdf_pkg, mfdf_if, mfdf_front, mfdf_queue and mfdf_back.

// The block accepts one 12-bit ADC sample per clock cycle while the queue has
// room and returns one flow result for every fifth sample: flow in litres per
// minute (10-bit two's complement), a held flag when the deadband repeats the
// last reported value, and a clipped flag when the rounded value was saturated.
// The median of a group is found by a comparison network in the same cycle as
// its fifth sample; the median then waits in a two-entry queue and passes a
// three-stage back end (multiply, offset with rounding, deadband test into the
// output register). A stalled output freezes the back end only; samples keep
// being taken until the queue holds two medians. Configuration is written
// through cfg_we/cfg_index/cfg_data: index 0 gain, 1 offset, 2 deadband,
// all Q16.

module median_flow_deadband_filter_top (
    input  logic                           clk,
    input  logic                           rst_n,
    mfdf_sample_if.sink                    samples,
    mfdf_result_if.source                  results,
    input  logic                           cfg_we,
    input  logic [mfdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mfdf_pkg::CFG_W-1:0]     cfg_data
);

    mfdf_pkg::mfdf_item_t push;
    mfdf_pkg::mfdf_item_t head;
    mfdf_pkg::mfdf_cfg_t  cfg;
    logic                 queue_full;
    logic                 pop;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // Sample collection and median selection.
    mfdf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .queue_full (queue_full),
        .push       (push)
    );

    // Median queue.
    mfdf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    // Scaling, rounding and deadband.
    mfdf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

// ----- src/mfdf_checker.sv -----
// Port-level checks on the result channel of the median flow deadband filter.
// Depends on mfdf_pkg; attached to median_flow_deadband_filter_top by bind.

module mfdf_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               res_valid,
    input logic                               res_ready,
    input logic signed [mfdf_pkg::FLOW_W-1:0] res_flow,
    input logic                               res_held,
    input logic                               res_clipped
);

    logic signed [mfdf_pkg::FLOW_W-1:0] last_flow_reg;

    // Last flow delivered on the result channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_flow_reg <= '0;
        end
        else if (res_valid && res_ready)
        begin
            last_flow_reg <= res_flow;
        end
    end

    // A stalled result transaction keeps its valid and payload.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_flow)
                                    && $stable(res_held) && $stable(res_clipped))
        else $error("result changed while stalled");

    // A held result repeats the previously delivered flow.
    a_held_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_held |-> res_flow == last_flow_reg)
        else $error("held result differs from last flow");

    // A held result is never also clipped.
    a_held_not_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_held && res_clipped))
        else $error("result both held and clipped");

    // A clipped result sits at one end of the range.
    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_clipped |->
            res_flow == mfdf_pkg::FLOW_MAX_CODE || res_flow == mfdf_pkg::FLOW_MIN_CODE)
        else $error("clipped result not at range limit");

endmodule

bind median_flow_deadband_filter_top mfdf_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (results.valid),
    .res_ready   (results.ready),
    .res_flow    (results.flow),
    .res_held    (results.held),
    .res_clipped (results.clipped)
);

// ----- test/mfdf_flow_checker.sv -----
`timescale 1ns / 1ps
// Passive checker for the median flow deadband filter: it follows the register writes,
// predicts each flow result from accepted samples and compares the result channel.
// Depends on mfdf_pkg and the channel interfaces in mfdf_if.

module mfdf_flow_checker
    import mfdf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    mfdf_sample_if               samples,
    mfdf_result_if               results,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   pending,
    output int                   flows_seen,
    output int                   held_seen,
    output int                   clipped_seen
);

    localparam longint Q16_ONE  = longint'(1) << FRAC_W;
    localparam longint Q16_HALF = Q16_ONE / 2;

    typedef struct packed {
        logic signed [FLOW_W-1:0] flow;
        logic                     held;
        logic                     clipped;
    } flow_result_t;

    // Our own copy of the registers and of the filter state.
    logic [GAIN_W-1:0]        gain_reg;
    logic [OFFSET_W-1:0]      offset_reg;
    logic [DEADBAND_W-1:0]    deadband_reg;
    logic [ADC_BITS-1:0]      group [SAMPLES];
    int                       group_fill;
    logic signed [FLOW_W-1:0] last_flow;

    // Flow results predicted but not yet seen on the result channel.
    flow_result_t pending_flows [$];

    // Middle element of the group once sorted in ascending order.
    function automatic logic [ADC_BITS-1:0] group_median(input logic [ADC_BITS-1:0] g [SAMPLES]);
        logic [ADC_BITS-1:0] s [SAMPLES];
        logic [ADC_BITS-1:0] t;
        s = g;
        for (int i = 0; i < SAMPLES - 1; i++)
        begin
            for (int j = 0; j < SAMPLES - 1 - i; j++)
            begin
                if (s[j] > s[j + 1])
                begin
                    t        = s[j];
                    s[j]     = s[j + 1];
                    s[j + 1] = t;
                end
            end
        end
        return s[MEDIAN_POS];
    endfunction

    // Scales a median to Q16 flow, applies the deadband, then rounds and saturates.
    function automatic flow_result_t flow_from_median(input logic [ADC_BITS-1:0] med);
        longint       fq;
        longint       gap;
        longint       mag;
        longint       rounded;
        flow_result_t r;
        fq  = longint'(med) * longint'(gain_reg) - longint'(offset_reg);
        gap = fq - longint'(last_flow) * Q16_ONE;
        if (gap < 0)
            gap = -gap;
        r.held    = 1'b0;
        r.clipped = 1'b0;
        if (gap < longint'(deadband_reg))
        begin
            r.held = 1'b1;
            r.flow = last_flow;
        end
        else
        begin
            // Round half away from zero on the magnitude, then restore the sign.
            mag     = (fq < 0) ? -fq : fq;
            rounded = (mag + Q16_HALF) / Q16_ONE;
            if (fq < 0)
                rounded = -rounded;
            if (rounded > FLOW_MAX_MAG)
            begin
                rounded   = FLOW_MAX_MAG;
                r.clipped = 1'b1;
            end
            else if (rounded < -FLOW_MIN_MAG)
            begin
                rounded   = -FLOW_MIN_MAG;
                r.clipped = 1'b1;
            end
            r.flow = rounded[FLOW_W-1:0];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        flow_result_t want;
        flow_result_t got;
        if (!rst_n)
        begin
            gain_reg     = GAIN_RESET;
            offset_reg   = OFFSET_RESET;
            deadband_reg = DEADBAND_RESET;
            group_fill   = 0;
            last_flow    = '0;
            pending_flows.delete();
            errors       = 0;
            flows_seen   = 0;
            held_seen    = 0;
            clipped_seen = 0;
            pending     <= 0;
        end
        else
        begin
            // Register writes; bits above a register's width are dropped.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN:     gain_reg     = cfg_data[GAIN_W-1:0];
                    REG_OFFSET:   offset_reg   = cfg_data[OFFSET_W-1:0];
                    REG_DEADBAND: deadband_reg = cfg_data[DEADBAND_W-1:0];
                    default:      ;
                endcase
            end

            // A result transaction is compared with the oldest prediction.
            if (results.valid && results.ready)
            begin
                got.flow    = results.flow;
                got.held    = results.held;
                got.clipped = results.clipped;
                flows_seen++;
                held_seen    += got.held;
                clipped_seen += got.clipped;
                if (pending_flows.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result flow=%0d held=%0b clipped=%0b", $time,
                             $signed(got.flow), got.held, got.clipped);
                end
                else
                begin
                    want = pending_flows.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display({"%0t: result mismatch: expected flow=%0d held=%0b ",
                                  "clipped=%0b, actual flow=%0d held=%0b clipped=%0b"},
                                 $time, $signed(want.flow), want.held, want.clipped,
                                 $signed(got.flow), got.held, got.clipped);
                    end
                end
            end

            // A sample transaction fills the group; the last one of a group yields a result.
            if (samples.valid && samples.ready)
            begin
                if (group_fill < SAMPLES - 1)
                begin
                    group[group_fill] = samples.sample;
                    group_fill++;
                end
                else
                begin
                    group[SAMPLES-1] = samples.sample;
                    group_fill       = 0;
                    want             = flow_from_median(group_median(group));
                    last_flow        = want.flow;
                    pending_flows.push_back(want);
                end
            end

            pending <= pending_flows.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the median flow deadband filter: clock, reset, sample stimulus,
// result back-pressure, register programming and the final verdict.
// Depends on mfdf_pkg, mfdf_if, the filter RTL and mfdf_flow_checker.

module tb_top;
    import mfdf_pkg::*;

    // Index beyond the register map; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int GROUPS_PER_PHASE = 47;
    localparam int SETTLE_CYCLES    = 10;
    localparam int ADC_MAX          = (1 << ADC_BITS) - 1;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int send_idle_pct;
    int recv_stall_pct;
    int samples_sent;
    int centre;

    int chk_errors;
    int chk_pending;
    int chk_flows;
    int chk_held;
    int chk_clipped;

    mfdf_sample_if sample_ch ();
    mfdf_result_if result_ch ();

    median_flow_deadband_filter_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mfdf_flow_checker u_flow_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (sample_ch),
        .results      (result_ch),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (chk_errors),
        .pending      (chk_pending),
        .flows_seen   (chk_flows),
        .held_seen    (chk_held),
        .clipped_seen (chk_clipped)
    );

    // 12 ns clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result back-pressure: ready is redrawn on every rising edge.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #4000000;
        $display("Timeout with %0d flow results still outstanding.", chk_pending);
        $display("TEST FAILED");
        $finish;
    end

    function automatic int clamp_sample(input int v);
        return (v < 0) ? 0 : ((v > ADC_MAX) ? ADC_MAX : v);
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SENDER)   ? 59 : ((mode == IDLE_BOTH) ? 33 : 0);
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 59 : ((mode == IDLE_BOTH) ? 33 : 0);
    endtask

    // Offers one sample and returns at the edge where the transaction completes.
    task automatic send_sample(input int value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value[ADC_BITS-1:0];
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        samples_sent++;
    endtask

    task automatic send_group(input int a, input int b, input int c, input int d, input int e);
        send_sample(a);
        send_sample(b);
        send_sample(c);
        send_sample(d);
        send_sample(e);
    endtask

    // Mostly groups clustered round a slowly drifting level, so that the deadband
    // is often just met or just missed; the rest are scattered or extreme values.
    task automatic send_random_groups(input int count);
        int kind;
        int v;
        for (int g = 0; g < count; g++) begin
            kind = $urandom_range(9);
            if (kind >= 8)
                centre = $urandom_range(ADC_MAX);
            else if (kind <= 3)
                centre = clamp_sample(centre + int'($urandom_range(16)) - 8);
            for (int k = 0; k < SAMPLES; k++) begin
                if (kind <= 3 || kind >= 8)
                    v = centre + int'($urandom_range(6)) - 3;
                else if (kind <= 6)
                    v = $urandom_range(ADC_MAX);
                else
                    v = ($urandom_range(2) == 0) ? $urandom_range(ADC_MAX)
                                                 : (($urandom_range(1) == 0) ? 0 : ADC_MAX);
                send_sample(clamp_sample(v));
            end
        end
        sample_ch.valid <= 1'b0;
    endtask

    // Waits until every predicted result has arrived and the pipeline has drained.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (chk_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] offset,
                                input logic [CFG_W-1:0] deadband, input bit poke_unused);
        write_reg(REG_GAIN, gain);
        write_reg(REG_OFFSET, offset);
        if (poke_unused)
            write_reg(REG_UNUSED, {CFG_W{1'b1}});
        write_reg(REG_DEADBAND, deadband);
        cfg_we <= 1'b0;
    endtask

    task automatic program_random_regs(input bit poke_unused);
        program_regs({8'($urandom), 16'($urandom >> $urandom_range(10))},
                     24'($urandom) >> $urandom_range(6),
                     {6'($urandom), 18'($urandom >> $urandom_range(14))}, poke_unused);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_GAIN;
        cfg_data         = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        samples_sent     = 0;
        centre           = ADC_MAX / 2;
        set_idling(IDLE_NONE);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: full-scale and alternating-bit samples; the second
        // group has the same median, so the deadband holds the flow.
        send_group(ADC_MAX, 0, ADC_MAX, 0, 'h800);
        send_group('h555, ADC_MAX, 0, 'hAAA, 'h800);
        send_random_groups(GROUPS_PER_PHASE);

        // Gain one half, offset two and a half, no deadband: exact halves round
        // away from zero on both sides, and an unchanged flow is not held.
        wait_idle();
        program_regs({8'($urandom), 16'd32768}, 24'd163840, {6'($urandom), 18'd0}, 1'b0);
        set_idling(IDLE_SENDER);
        send_group(0, 0, 0, 0, 0);
        send_group(10, 0, 10, ADC_MAX, 10);
        send_group(11, ADC_MAX, 11, 11, 0);
        send_random_groups(GROUPS_PER_PHASE);

        // Largest gain, no offset, widest deadband: large medians saturate.
        wait_idle();
        program_regs({8'($urandom), 16'hFFFF}, 24'd0, {6'($urandom), 18'h3FFFF}, 1'b0);
        set_idling(IDLE_RECEIVER);
        send_random_groups(GROUPS_PER_PHASE);

        // No gain, largest offset: the flow sits at -256, half of its most negative value.
        // Two stray samples then shift the group boundaries for the later phases.
        wait_idle();
        program_regs({8'($urandom), 16'd0}, 24'hFFFFFF,
                     {6'($urandom), 18'($urandom_range(4))}, 1'b0);
        set_idling(IDLE_BOTH);
        send_random_groups(GROUPS_PER_PHASE);
        send_sample($urandom_range(ADC_MAX));
        send_sample($urandom_range(ADC_MAX));
        sample_ch.valid <= 1'b0;

        // Random settings under each idling pattern; the last one also writes
        // to the unused index.
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            program_random_regs(p == 3);
            set_idling(idle_mode_t'(p));
            send_random_groups(GROUPS_PER_PHASE);
        end

        wait_idle();
        $display("Sent %0d samples under eight register settings and four idling patterns.",
                 samples_sent);
        $display("Checked %0d flow results: %0d held by the deadband, %0d saturated.",
                 chk_flows, chk_held, chk_clipped);
        if (chk_errors == 0 && chk_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- median_flow_deadband_filter_top.f -----
src/mfdf_pkg.sv
src/mfdf_if.sv
src/mfdf_front.sv
src/mfdf_queue.sv
src/mfdf_back.sv
src/median_flow_deadband_filter_top.sv
src/mfdf_checker.sv
test/mfdf_flow_checker.sv
test/tb_top.sv
